// ===== sv/pngs_pkg.sv =====
// Shared types, constants and helper functions for the pseudo-Newtonian gravity source.
// Used by pseudo_newtonian_gravity_source and its bench; depends on nothing else.
`default_nettype none

package pngs_pkg;

	// Fixed-point format of all values.
	localparam int WORD_BITS = 32;
	localparam int FRAC_BITS = 16;
	localparam int REG_BITS  = 31;

	// Stream widths.
	localparam int IN_BITS  = 352;
	localparam int OUT_BITS = 128;

	// Iterative steps of the pipelined units.
	localparam int SQRT_STEPS = 32;
	localparam int DIV1_STEPS = 48;
	localparam int DIV2_STEPS = 47;
	localparam int DIV3_STEPS = 47;
	localparam int DIV4_STEPS = 63;

	// Pipeline stage numbers (where each value is first registered).
	localparam int ST_SQ   = 1;
	localparam int ST_SUM  = 2;
	localparam int ST_ROOT = ST_SUM + SQRT_STEPS;
	localparam int ST_U    = ST_ROOT + DIV1_STEPS;
	localparam int ST_D    = ST_U + 1;
	localparam int ST_A    = ST_D + DIV2_STEPS;
	localparam int ST_PULL = ST_A + DIV3_STEPS;
	localparam int ST_GP   = ST_PULL + 1;
	localparam int ST_G    = ST_GP + DIV4_STEPS;
	localparam int ST_E1   = ST_G + 1;
	localparam int ST_E2   = ST_G + 2;
	localparam int ST_E3   = ST_G + 3;
	localparam int ST_E4   = ST_G + 4;
	localparam int ST_E5   = ST_G + 5;
	localparam int ST_E6   = ST_G + 6;
	localparam int ST_LAST = ST_G + 7;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_GRAV_RADIUS  = 2'd0,
		REG_PEAK_ACCEL   = 2'd1,
		REG_TIME_STEP    = 2'd2,
		REG_ENERGY_UPDATE = 2'd3
	} cfg_reg_t;

	// Per-item values that travel along the whole pipeline.
	typedef struct packed {
		logic [2:0][31:0] pmag;
		logic [2:0]       pneg;
		logic [2:0][31:0] vel;
		logic [2:0][31:0] mom;
		logic [31:0]      energy;
		logic [30:0]      density;
		logic             fault;
		logic             far;
		logic [31:0]      r;
		logic [47:0]      d;
		logic [32:0]      nw;
		logic             eneg;
	} pay_t;

	// Magnitude of a signed word, as an unsigned word.
	function automatic logic [31:0] mag32(input logic [31:0] v);
		return v[31] ? (32'd0 - v) : v;
	endfunction

	// Clip a delta at 2^32; any larger delta saturates the output anyway.
	function automatic logic [32:0] cap32(input logic [64:0] v);
		return (v > 65'h1_0000_0000) ? 33'h1_0000_0000 : v[32:0];
	endfunction

	// Add or subtract a delta from a signed word and saturate.
	function automatic logic [31:0] apply_delta(input logic [31:0] v, input logic [32:0] dl,
			input logic add);
		logic signed [34:0] s;
		logic signed [34:0] ve;
		logic signed [34:0] de;
		ve = $signed({{3{v[31]}}, v});
		de = $signed({2'b00, dl});
		s = add ? (ve + de) : (ve - de);
		if (s > 35'sh0_7FFF_FFFF) begin
			return 32'h7FFF_FFFF;
		end else if (s < -35'sh0_8000_0000) begin
			return 32'h8000_0000;
		end
		return s[31:0];
	endfunction

endpackage

`default_nettype wire

// ===== sv/pseudo_newtonian_gravity_source.sv =====
// Pseudo-Newtonian gravity source term: top level and complete pipelined datapath.
// Depends on pngs_pkg for stage numbers, payload type and saturation helpers.
//
// Usage: one grid cell enters per request on the s_axis channel and one updated
// result leaves per request on the m_axis channel, in order. Configuration registers
// are written through cfg_we / cfg_index / cfg_data; the user must write them only
// while no cell is in flight, as the block does not enforce it. The pipeline accepts
// one cell every cycle unless the output stalls. Its square root has 32 stages, one
// bit each, and its restoring dividers 48, 47, 47 and (three in parallel) 63 stages.
// The whole pipeline advances together: while a result waits at the output and
// m_axis_tready is low, every stage holds and s_axis_tready is low; nothing is lost
// or repeated. Bubbles travel as cleared valid bits. Reset clears all valid bits and
// loads the registers with their defaults (radius 1.0, peak 1.0, dt 655, energy on).
// A cell at the origin passes momentum and energy through and raises the fault flag.
`default_nettype none

module pseudo_newtonian_gravity_source
	import pngs_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [REG_BITS-1:0] cfg_data,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	// pos_x, pos_y, pos_z, density, vel_x, vel_y, vel_z, mom_x_in, mom_y_in,
	// mom_z_in, energy_in, one zero pad bit
	input  logic [IN_BITS-1:0]  s_axis_tdata,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	// mom_x_out, mom_y_out, mom_z_out, energy_out
	output logic [OUT_BITS-1:0] m_axis_tdata,
	// origin_fault
	output logic                m_axis_tuser
);

	// Configuration registers.
	logic [REG_BITS-1:0] grav_radius_q;
	logic [REG_BITS-1:0] peak_accel_q;
	logic [REG_BITS-1:0] time_step_q;
	logic                energy_update_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grav_radius_q   <= 31'd65536;
			peak_accel_q    <= 31'd65536;
			time_step_q     <= 31'd655;
			energy_update_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_GRAV_RADIUS:   grav_radius_q   <= cfg_data;
				REG_PEAK_ACCEL:    peak_accel_q    <= cfg_data;
				REG_TIME_STEP:     time_step_q     <= cfg_data;
				REG_ENERGY_UPDATE: energy_update_q <= cfg_data[0];
				default:           grav_radius_q   <= grav_radius_q;
			endcase
		end
	end

	// A zero radius acts as the smallest step.
	logic [REG_BITS-1:0] rgv;
	logic [32:0]         rg3;
	assign rgv = (grav_radius_q == '0) ? 31'd1 : grav_radius_q;
	assign rg3 = {1'b0, rgv, 1'b0} + {2'b00, rgv};

	// Global pipeline advance: everything moves unless a result is held.
	logic adv;
	logic vld_s [1:ST_LAST];
	assign adv           = !vld_s[ST_LAST] || m_axis_tready;
	assign s_axis_tready = adv;
	assign m_axis_tvalid = vld_s[ST_LAST];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= ST_LAST; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else if (adv) begin
			vld_s[1] <= s_axis_tvalid;
			for (int i = 2; i <= ST_LAST; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
		end
	end

	// Payload registers and unit registers.
	pay_t        pay_s [1:ST_LAST];
	logic [63:0] sq_s1 [0:2];
	logic [63:0] sum_s2;

	logic [63:0] sqrt_rem_s  [0:SQRT_STEPS-1];
	logic [31:0] sqrt_root_s [0:SQRT_STEPS-1];
	logic [63:0] sqrt_rem_nx  [0:SQRT_STEPS-1];
	logic [31:0] sqrt_root_nx [0:SQRT_STEPS-1];

	logic [30:0] d1_rem_s  [0:DIV1_STEPS-1];
	logic [47:0] d1_q_s    [0:DIV1_STEPS-1];
	logic [30:0] d1_rem_nx [0:DIV1_STEPS-1];
	logic [47:0] d1_q_nx   [0:DIV1_STEPS-1];

	logic [47:0] d2_rem_s  [0:DIV2_STEPS-1];
	logic [31:0] d2_q_s    [0:DIV2_STEPS-1];
	logic [47:0] d2_rem_nx [0:DIV2_STEPS-1];
	logic [31:0] d2_q_nx   [0:DIV2_STEPS-1];

	logic [47:0] d3_rem_s  [0:DIV3_STEPS-1];
	logic [46:0] d3_num_s  [0:DIV3_STEPS-1];
	logic [47:0] d3_den_s  [0:DIV3_STEPS-1];
	logic [31:0] d3_q_s    [0:DIV3_STEPS-1];
	logic [47:0] d3_rem_nx [0:DIV3_STEPS-1];
	logic [46:0] d3_num_nx [0:DIV3_STEPS-1];
	logic [47:0] d3_den_nx [0:DIV3_STEPS-1];
	logic [31:0] d3_q_nx   [0:DIV3_STEPS-1];

	logic [63:0] gp_s [0:2];
	logic [31:0] d4_rem_s  [0:2][0:DIV4_STEPS-1];
	logic [62:0] d4_num_s  [0:2][0:DIV4_STEPS-1];
	logic [31:0] d4_rem_nx [0:2][0:DIV4_STEPS-1];
	logic [62:0] d4_num_nx [0:2][0:DIV4_STEPS-1];

	// Tail stages: power, time step and density scaling, saturation.
	logic [62:0] vg_se1  [0:2];
	logic [30:0] g_se1   [0:2];
	logic [47:0] pmag_se2;
	logic [61:0] gdt_se2 [0:2];
	logic [62:0] ph_se3;
	logic [46:0] pl_se3;
	logic [45:0] tm_se3  [0:2];
	logic [48:0] te_se4;
	logic [60:0] mh_se4  [0:2];
	logic [46:0] ml_se4  [0:2];
	logic [63:0] eh_se5;
	logic [46:0] el_se5;
	logic [32:0] md_se5  [0:2];
	logic [32:0] ed_se6;
	logic [31:0] mo_se6  [0:2];
	logic [OUT_BITS-1:0] out_data_se7;
	logic                out_fault_se7;

	// Signed power sum over the three axes.
	logic signed [49:0] pw_sum;
	logic [47:0]        pw_mag;

	always_comb begin
		logic signed [49:0] term;
		pw_sum = '0;
		for (int i = 0; i < 3; i++) begin
			term = $signed({3'b000, vg_se1[i][62:16]});
			if (pay_s[ST_E1].pneg[i] ^ pay_s[ST_E1].vel[i][31]) begin
				pw_sum = pw_sum - term;
			end else begin
				pw_sum = pw_sum + term;
			end
		end
		pw_mag = pw_sum[49] ? 48'(-pw_sum) : pw_sum[47:0];
	end

	// Payload entering the stages that fill in their own fields.
	pay_t sum_pay;
	pay_t root_pay;
	pay_t d_pay;
	pay_t e2_pay;

	always_comb begin
		sum_pay        = pay_s[ST_SUM-1];
		sum_pay.fault  = ((sq_s1[0] | sq_s1[1] | sq_s1[2]) == '0);
		root_pay       = pay_s[ST_ROOT];
		root_pay.r     = sqrt_root_s[SQRT_STEPS-1];
		root_pay.far   = ({1'b0, sqrt_root_s[SQRT_STEPS-1]} >= rg3);
		d_pay          = pay_s[ST_D-1];
		d_pay.d        = d1_q_s[DIV1_STEPS-1] - 48'd131072;
		d_pay.nw       = 33'((49'(d1_q_s[DIV1_STEPS-1][17:0]) *
			49'(peak_accel_q)) >> FRAC_BITS);
		e2_pay         = pay_s[ST_E2-1];
		e2_pay.eneg    = pw_sum[49];
	end

	// Square root, one result bit per stage.
	always_comb begin
		logic [63:0] rem_i;
		logic [31:0] root_i;
		logic [63:0] cand;
		for (int j = 0; j < SQRT_STEPS; j++) begin
			if (j == 0) begin
				rem_i  = sum_s2;
				root_i = '0;
			end else begin
				rem_i  = sqrt_rem_s[j-1];
				root_i = sqrt_root_s[j-1];
			end
			cand = ({32'd0, root_i} << (SQRT_STEPS - j)) |
				(64'd1 << (2 * (SQRT_STEPS - 1 - j)));
			if (rem_i >= cand) begin
				sqrt_rem_nx[j]  = rem_i - cand;
				sqrt_root_nx[j] = root_i | (32'd1 << (SQRT_STEPS - 1 - j));
			end else begin
				sqrt_rem_nx[j]  = rem_i;
				sqrt_root_nx[j] = root_i;
			end
		end
	end

	// Divider for u = r * 2^F / radius.
	always_comb begin
		logic [30:0] rem_i;
		logic [47:0] q_i;
		logic [31:0] r_i;
		logic        nb;
		logic [31:0] sh;
		logic        tk;
		for (int j = 0; j < DIV1_STEPS; j++) begin
			if (j == 0) begin
				rem_i = '0;
				q_i   = '0;
				r_i   = sqrt_root_s[SQRT_STEPS-1];
			end else begin
				rem_i = d1_rem_s[j-1];
				q_i   = d1_q_s[j-1];
				r_i   = pay_s[ST_ROOT+j].r;
			end
			nb = (j < 32) ? r_i[5'(31 - j)] : 1'b0;
			sh = {rem_i, nb};
			tk = (sh >= {1'b0, rgv});
			d1_rem_nx[j] = tk ? 31'(sh - {1'b0, rgv}) : sh[30:0];
			d1_q_nx[j]   = {q_i[46:0], tk};
		end
	end

	// Divider for a = peak * 2^F / d.
	always_comb begin
		logic [47:0] rem_i;
		logic [31:0] q_i;
		logic [47:0] den_i;
		logic        nb;
		logic [48:0] sh;
		logic        tk;
		for (int j = 0; j < DIV2_STEPS; j++) begin
			if (j == 0) begin
				rem_i = '0;
				q_i   = '0;
			end else begin
				rem_i = d2_rem_s[j-1];
				q_i   = d2_q_s[j-1];
			end
			den_i = pay_s[ST_D+j].d;
			nb = (j < 31) ? peak_accel_q[5'(30 - j)] : 1'b0;
			sh = {rem_i, nb};
			tk = (sh >= {1'b0, den_i});
			d2_rem_nx[j] = tk ? 48'(sh - {1'b0, den_i}) : sh[47:0];
			d2_q_nx[j]   = {q_i[30:0], tk};
		end
	end

	// Divider for the pull: a * 2^F / d far out, or the near product / 3.
	always_comb begin
		logic [47:0] rem_i;
		logic [46:0] num_i;
		logic [47:0] den_i;
		logic [31:0] q_i;
		logic [48:0] sh;
		logic        tk;
		for (int j = 0; j < DIV3_STEPS; j++) begin
			if (j == 0) begin
				rem_i = '0;
				q_i   = '0;
				if (pay_s[ST_A].far) begin
					num_i = {d2_q_s[DIV2_STEPS-1][30:0], 16'd0};
					den_i = pay_s[ST_A].d;
				end else begin
					num_i = {14'd0, pay_s[ST_A].nw};
					den_i = 48'd3;
				end
			end else begin
				rem_i = d3_rem_s[j-1];
				q_i   = d3_q_s[j-1];
				num_i = d3_num_s[j-1];
				den_i = d3_den_s[j-1];
			end
			sh = {rem_i, num_i[6'(46 - j)]};
			tk = (sh >= {1'b0, den_i});
			d3_rem_nx[j] = tk ? 48'(sh - {1'b0, den_i}) : sh[47:0];
			d3_q_nx[j]   = {q_i[30:0], tk};
			d3_num_nx[j] = num_i;
			d3_den_nx[j] = den_i;
		end
	end

	// Three dividers for g = pull * |pos| / r; quotient bits shift into the numerator.
	always_comb begin
		logic [31:0] rem_i;
		logic [62:0] num_i;
		logic [31:0] r_i;
		logic [32:0] sh;
		logic        tk;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < DIV4_STEPS; j++) begin
				if (j == 0) begin
					rem_i = '0;
					num_i = gp_s[i][62:0];
				end else begin
					rem_i = d4_rem_s[i][j-1];
					num_i = d4_num_s[i][j-1];
				end
				r_i = pay_s[ST_GP+j].r;
				sh = {rem_i, num_i[62]};
				tk = (sh >= {1'b0, r_i});
				d4_rem_nx[i][j] = tk ? 32'(sh - {1'b0, r_i}) : sh[31:0];
				d4_num_nx[i][j] = {num_i[61:0], tk};
			end
		end
	end

	// Datapath registers, all held while the output stalls.
	always_ff @(posedge clk) begin
		if (adv) begin
			// Payload moves one stage; some stages fill in their own fields.
			for (int i = 2; i <= ST_LAST; i++) begin
				if (i == ST_SUM) begin
					pay_s[i] <= sum_pay;
				end else if (i == ST_ROOT + 1) begin
					pay_s[i] <= root_pay;
				end else if (i == ST_D) begin
					pay_s[i] <= d_pay;
				end else if (i == ST_E2) begin
					pay_s[i] <= e2_pay;
				end else begin
					pay_s[i] <= pay_s[i-1];
				end
			end

			// Input decode, magnitudes and squares.
			pay_s[1].pmag[0] <= mag32(s_axis_tdata[31:0]);
			pay_s[1].pmag[1] <= mag32(s_axis_tdata[63:32]);
			pay_s[1].pmag[2] <= mag32(s_axis_tdata[95:64]);
			pay_s[1].pneg    <= {s_axis_tdata[95], s_axis_tdata[63], s_axis_tdata[31]};
			pay_s[1].density <= s_axis_tdata[126:96];
			pay_s[1].vel[0]  <= s_axis_tdata[158:127];
			pay_s[1].vel[1]  <= s_axis_tdata[190:159];
			pay_s[1].vel[2]  <= s_axis_tdata[222:191];
			pay_s[1].mom[0]  <= s_axis_tdata[254:223];
			pay_s[1].mom[1]  <= s_axis_tdata[286:255];
			pay_s[1].mom[2]  <= s_axis_tdata[318:287];
			pay_s[1].energy  <= s_axis_tdata[350:319];
			pay_s[1].fault   <= 1'b0;
			pay_s[1].far     <= 1'b0;
			pay_s[1].r       <= '0;
			pay_s[1].d       <= '0;
			pay_s[1].nw      <= '0;
			pay_s[1].eneg    <= 1'b0;
			sq_s1[0] <= 64'(mag32(s_axis_tdata[31:0])) * 64'(mag32(s_axis_tdata[31:0]));
			sq_s1[1] <= 64'(mag32(s_axis_tdata[63:32])) * 64'(mag32(s_axis_tdata[63:32]));
			sq_s1[2] <= 64'(mag32(s_axis_tdata[95:64])) * 64'(mag32(s_axis_tdata[95:64]));

			// Squared distance; the origin check travels with the payload.
			sum_s2 <= sq_s1[0] + sq_s1[1] + sq_s1[2];

			// Square root steps.
			for (int j = 0; j < SQRT_STEPS; j++) begin
				sqrt_rem_s[j]  <= sqrt_rem_nx[j];
				sqrt_root_s[j] <= sqrt_root_nx[j];
			end

			// Radius division steps.
			for (int j = 0; j < DIV1_STEPS; j++) begin
				d1_rem_s[j] <= d1_rem_nx[j];
				d1_q_s[j]   <= d1_q_nx[j];
			end

			for (int j = 0; j < DIV2_STEPS; j++) begin
				d2_rem_s[j] <= d2_rem_nx[j];
				d2_q_s[j]   <= d2_q_nx[j];
			end
			for (int j = 0; j < DIV3_STEPS; j++) begin
				d3_rem_s[j] <= d3_rem_nx[j];
				d3_q_s[j]   <= d3_q_nx[j];
				d3_num_s[j] <= d3_num_nx[j];
				d3_den_s[j] <= d3_den_nx[j];
			end

			// Pull times each position magnitude.
			for (int i = 0; i < 3; i++) begin
				gp_s[i] <= 64'(d3_q_s[DIV3_STEPS-1][30:0]) * 64'(pay_s[ST_PULL].pmag[i]);
			end
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < DIV4_STEPS; j++) begin
					d4_rem_s[i][j] <= d4_rem_nx[i][j];
					d4_num_s[i][j] <= d4_num_nx[i][j];
				end
			end

			// Velocity times pull per axis.
			for (int i = 0; i < 3; i++) begin
				g_se1[i]  <= d4_num_s[i][DIV4_STEPS-1][30:0];
				vg_se1[i] <= 63'(mag32(pay_s[ST_G].vel[i])) *
					63'(d4_num_s[i][DIV4_STEPS-1][30:0]);
			end

			// Power magnitude; pull times dt per axis.
			pmag_se2 <= pw_mag;
			for (int i = 0; i < 3; i++) begin
				gdt_se2[i] <= 62'(g_se1[i]) * 62'(time_step_q);
			end

			// Power times dt in two partial products; momentum t values.
			ph_se3 <= 63'(pmag_se2[47:16]) * 63'(time_step_q);
			pl_se3 <= 47'(pmag_se2[15:0]) * 47'(time_step_q);
			for (int i = 0; i < 3; i++) begin
				tm_se3[i] <= gdt_se2[i][61:16];
			end

			// Energy t with clip; momentum t times density partials.
			if ((ph_se3 + 63'(pl_se3[46:16])) > 63'h1_0000_0000_0000) begin
				te_se4 <= 49'h1_0000_0000_0000;
			end else begin
				te_se4 <= 49'(ph_se3 + 63'(pl_se3[46:16]));
			end
			for (int i = 0; i < 3; i++) begin
				mh_se4[i] <= 61'(tm_se3[i][45:16]) * 61'(pay_s[ST_E3].density);
				ml_se4[i] <= 47'(tm_se3[i][15:0]) * 47'(pay_s[ST_E3].density);
			end

			// Energy t times density partials; momentum deltas.
			eh_se5 <= 64'(te_se4[48:16]) * 64'(pay_s[ST_E4].density);
			el_se5 <= 47'(te_se4[15:0]) * 47'(pay_s[ST_E4].density);
			for (int i = 0; i < 3; i++) begin
				md_se5[i] <= cap32(65'(mh_se4[i]) + 65'(ml_se4[i][46:16]));
			end

			// Energy delta; saturated momentum.
			ed_se6 <= cap32(65'(eh_se5) + 65'(el_se5[46:16]));
			for (int i = 0; i < 3; i++) begin
				mo_se6[i] <= apply_delta(pay_s[ST_E5].mom[i], md_se5[i],
					pay_s[ST_E5].pneg[i]);
			end

			// Output register with origin and energy-disable bypass.
			if (pay_s[ST_E6].fault) begin
				out_data_se7[95:0] <= {pay_s[ST_E6].mom[2], pay_s[ST_E6].mom[1],
					pay_s[ST_E6].mom[0]};
			end else begin
				out_data_se7[95:0] <= {mo_se6[2], mo_se6[1], mo_se6[0]};
			end
			if (pay_s[ST_E6].fault || !energy_update_q) begin
				out_data_se7[127:96] <= pay_s[ST_E6].energy;
			end else begin
				out_data_se7[127:96] <= apply_delta(pay_s[ST_E6].energy, ed_se6,
					pay_s[ST_E6].eneg);
			end
			out_fault_se7 <= pay_s[ST_E6].fault;
		end
	end

	assign m_axis_tdata = out_data_se7;
	assign m_axis_tuser = out_fault_se7;

endmodule

`default_nettype wire

// ===== dv/pseudo_newtonian_gravity_source_tb.sv =====
// Self-checking bench for the pseudo-Newtonian gravity source pipeline.
// Needs pngs_pkg and pseudo_newtonian_gravity_source; predicts every cell update itself.
`timescale 1ns / 1ps

module pseudo_newtonian_gravity_source_tb;
	import pngs_pkg::*;

	typedef struct {
		logic [31:0] pos [3];
		logic [30:0] density;
		logic [31:0] vel [3];
		logic [31:0] mom [3];
		logic [31:0] energy;
	} cell_t;

	typedef struct {
		logic [31:0] mom [3];
		logic [31:0] energy;
		logic        fault;
	} update_t;

	localparam longint unsigned ONE_Q = 64'd1 << FRAC_BITS;
	localparam longint unsigned OUT_CAP = 64'd1 << 33;
	localparam longint unsigned MID_CAP = 64'd1 << 49;
	localparam int CYCLE_LIMIT = 600000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [REG_BITS-1:0] cfg_data;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [IN_BITS-1:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [OUT_BITS-1:0] m_axis_tdata;
	logic m_axis_tuser;

	// Register copies used for prediction.
	longint unsigned radius_q;
	longint unsigned peak_q;
	longint unsigned dt_q;
	bit energy_on;

	cell_t pending_cells [$];
	update_t expected_updates [$];
	cell_t cur_cell;
	int send_gap;
	int recv_gap;
	int hold_cycles;
	bit hold_done;
	bit idle_enable;
	int accepted_cells;
	int mismatches;
	int cycles;

	pseudo_newtonian_gravity_source uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic longint unsigned int_sqrt(input longint unsigned n);
		longint unsigned root;
		longint unsigned step;
		root = 0;
		step = 64'd1 << 62;
		while (step > n) step = step >> 2;
		while (step != 0) begin
			if (n >= root + step) begin
				n = n - (root + step);
				root = (root >> 1) + step;
			end else begin
				root = root >> 1;
			end
			step = step >> 2;
		end
		return root;
	endfunction

	// Fixed-point product, clipped at a cap that already forces saturation.
	function automatic longint unsigned qmul(input longint unsigned a, input longint unsigned b,
			input longint unsigned cap);
		logic [127:0] p;
		p = ({64'd0, a} * {64'd0, b}) >> FRAC_BITS;
		return (p > cap) ? cap : p[63:0];
	endfunction

	function automatic logic [31:0] sat_word(input longint v);
		if (v > 64'sd2147483647) begin
			return 32'h7FFF_FFFF;
		end else if (v < -64'sd2147483648) begin
			return 32'h8000_0000;
		end
		return v[31:0];
	endfunction

	function automatic longint unsigned abs_word(input logic [31:0] v);
		longint s;
		s = longint'($signed(v));
		return (s < 0) ? longint'(-s) : longint'(s);
	endfunction

	// Gravity update of one cell under the current register values.
	function automatic update_t gravity_update(input cell_t c);
		update_t res;
		longint unsigned sumsq, r, rg, u, d, a, pull, gm, t, delta, pm;
		longint unsigned gmag [3];
		longint power;
		bit gneg [3];
		bit vneg;
		sumsq = 0;
		power = 0;
		for (int i = 0; i < 3; i++) sumsq += abs_word(c.pos[i]) * abs_word(c.pos[i]);
		res.energy = c.energy;
		res.fault = 1'b0;
		for (int i = 0; i < 3; i++) res.mom[i] = c.mom[i];
		if (sumsq == 0) begin
			res.fault = 1'b1;
			return res;
		end
		r = int_sqrt(sumsq);
		rg = (radius_q == 0) ? 1 : radius_q;
		u = (r << FRAC_BITS) / rg;
		if (r >= 3 * rg) begin
			d = u - 2 * ONE_Q;
			a = (peak_q << FRAC_BITS) / d;
			pull = (a << FRAC_BITS) / d;
		end else begin
			pull = (u * peak_q) / (3 * ONE_Q);
		end
		for (int i = 0; i < 3; i++) begin
			gm = (pull * abs_word(c.pos[i])) / r;
			gmag[i] = gm;
			gneg[i] = c.pos[i][31];
			t = qmul(gm, dt_q, MID_CAP);
			delta = qmul(t, c.density, OUT_CAP);
			res.mom[i] = gneg[i] ? sat_word(longint'($signed(c.mom[i])) + longint'(delta))
				: sat_word(longint'($signed(c.mom[i])) - longint'(delta));
		end
		if (energy_on) begin
			for (int i = 0; i < 3; i++) begin
				pm = qmul(abs_word(c.vel[i]), gmag[i], MID_CAP);
				vneg = c.vel[i][31];
				power += (vneg != gneg[i]) ? -longint'(pm) : longint'(pm);
			end
			t = qmul((power < 0) ? longint'(-power) : longint'(power), dt_q, MID_CAP);
			delta = qmul(t, c.density, OUT_CAP);
			res.energy = (power < 0) ? sat_word(longint'($signed(c.energy)) + longint'(delta))
				: sat_word(longint'($signed(c.energy)) - longint'(delta));
		end
		return res;
	endfunction

	function automatic logic [IN_BITS-1:0] pack_cell(input cell_t c);
		return {1'b0, c.energy, c.mom[2], c.mom[1], c.mom[0], c.vel[2], c.vel[1], c.vel[0],
			c.density, c.pos[2], c.pos[1], c.pos[0]};
	endfunction

	// Coordinate over many scales, so that cells land both near and far.
	function automatic logic [31:0] rand_coord();
		logic [31:0] v;
		case ($urandom_range(0, 9))
			0: v = 32'd0;
			1: v = $urandom;
			default: begin
				v = $urandom >> $urandom_range(1, 31);
				if ($urandom_range(0, 1)) v = -v;
			end
		endcase
		return v;
	endfunction

	function automatic logic [31:0] rand_value();
		logic [31:0] v;
		v = $urandom;
		if ($urandom_range(0, 2) == 0) v = $signed(v) >>> $urandom_range(0, 31);
		return v;
	endfunction

	function automatic cell_t rand_cell();
		cell_t c;
		for (int i = 0; i < 3; i++) begin
			c.pos[i] = rand_coord();
			c.vel[i] = rand_value();
			c.mom[i] = rand_value();
		end
		c.density = 31'($urandom >> $urandom_range(1, 31));
		c.energy = rand_value();
		return c;
	endfunction

	function automatic cell_t make_cell(input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] z, input logic [30:0] dens, input logic [31:0] v,
			input logic [31:0] m);
		cell_t c;
		c.pos[0] = x;
		c.pos[1] = y;
		c.pos[2] = z;
		c.density = dens;
		for (int i = 0; i < 3; i++) begin
			c.vel[i] = v;
			c.mom[i] = m;
		end
		c.energy = m;
		return c;
	endfunction

	// Request driver: offers queued cells with random gaps between them when idling.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				expected_updates.push_back(gravity_update(cur_cell));
				accepted_cells++;
				send_gap = idle_enable ? $urandom_range(0, 13) : 0;
			end
			if (s_axis_tvalid && !s_axis_tready) begin
				// Hold the offered cell until it is taken.
			end else if (send_gap > 0) begin
				send_gap--;
				s_axis_tvalid <= 1'b0;
			end else if (pending_cells.size() > 0) begin
				cur_cell = pending_cells.pop_front();
				s_axis_tdata <= pack_cell(cur_cell);
				s_axis_tvalid <= 1'b1;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Result acceptor: random stalls, plus one long hold-off that backs up the pipeline.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				recv_gap = idle_enable ? $urandom_range(0, 13) : 0;
			end
			if (!hold_done && accepted_cells >= 400) begin
				hold_done = 1'b1;
				hold_cycles = 900;
			end
			if (hold_cycles > 0) begin
				hold_cycles--;
				m_axis_tready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Result checker against the oldest prediction.
	always @(posedge clk) begin
		update_t want;
		logic [31:0] got [4];
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			for (int i = 0; i < 4; i++) got[i] = m_axis_tdata[32*i +: 32];
			if (expected_updates.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("Unexpected result %h fault %b", m_axis_tdata,
					m_axis_tuser);
			end else begin
				want = expected_updates.pop_front();
				if (got[0] !== want.mom[0] || got[1] !== want.mom[1] || got[2] !== want.mom[2]
						|| got[3] !== want.energy || m_axis_tuser !== want.fault) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("Wrong result: expected mom %h %h %h energy %h fault %b",
							want.mom[0], want.mom[1], want.mom[2], want.energy, want.fault);
						$display("              actual   mom %h %h %h energy %h fault %b",
							got[0], got[1], got[2], got[3], m_axis_tuser);
					end
				end
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic write_reg(input cfg_reg_t idx, input longint unsigned value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[REG_BITS-1:0];
		case (idx)
			REG_GRAV_RADIUS: radius_q = value & 64'h7FFF_FFFF;
			REG_PEAK_ACCEL: peak_q = value & 64'h7FFF_FFFF;
			REG_TIME_STEP: dt_q = value & 64'h7FFF_FFFF;
			REG_ENERGY_UPDATE: energy_on = value[0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		while (pending_cells.size() > 0 || s_axis_tvalid || expected_updates.size() > 0)
			@(posedge clk);
	endtask

	task automatic run_random(input int count);
		for (int i = 0; i < count; i++) pending_cells.push_back(rand_cell());
		drain();
	endtask

	// Stimulus phases, with register changes only while the pipeline is empty.
	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		radius_q = 65536;
		peak_q = 65536;
		dt_q = 655;
		energy_on = 1'b1;
		send_gap = 0;
		recv_gap = 0;
		hold_cycles = 0;
		hold_done = 1'b0;
		idle_enable = 1'b1;
		accepted_cells = 0;
		mismatches = 0;
		cycles = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed cells under reset values: origin, boundaries, extremes.
		pending_cells.push_back(make_cell(0, 0, 0, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000));
		pending_cells.push_back(make_cell(0, 0, 0, 31'd0, 32'h8000_0000, 32'h7FFF_FFFF));
		pending_cells.push_back(make_cell(32'h0001_0000, 0, 0, 31'h0001_0000, 32'h0001_0000, 0));
		pending_cells.push_back(make_cell(32'h0003_0000, 0, 0, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 0));
		pending_cells.push_back(make_cell(32'h0002_FFFF, 0, 0, 31'h7FFF_FFFF, 32'h8000_0000, 0));
		pending_cells.push_back(make_cell(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			31'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
		pending_cells.push_back(make_cell(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			31'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000));
		pending_cells.push_back(make_cell(32'hFFFF_FFFF, 1, 0, 31'h7FFF_FFFF, 32'hFFFF_FFFF,
			32'h7FFF_FFFF));
		pending_cells.push_back(make_cell(0, 32'hFFFF_0000, 0, 31'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000));
		pending_cells.push_back(make_cell(0, 0, 32'h0000_8000, 31'd1, 32'h0001_0000,
			32'h1234_5678));
		drain();
		run_random(400);

		// Strong pull: smallest radius, largest peak and step, energy left alone.
		write_reg(REG_GRAV_RADIUS, 1);
		write_reg(REG_PEAK_ACCEL, 64'h7FFF_FFFF);
		write_reg(REG_TIME_STEP, 64'h7FFF_FFFF);
		write_reg(REG_ENERGY_UPDATE, 0);
		pending_cells.push_back(make_cell(32'h0000_0001, 0, 0, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 0));
		pending_cells.push_back(make_cell(0, 0, 0, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
		pending_cells.push_back(make_cell(32'h8000_0000, 0, 0, 31'h7FFF_FFFF, 1, 32'h8000_0000));
		drain();
		run_random(300);

		// Largest radius, no pull, zero step, back-to-back traffic.
		idle_enable = 1'b0;
		write_reg(REG_GRAV_RADIUS, 64'h7FFF_FFFF);
		write_reg(REG_PEAK_ACCEL, 0);
		write_reg(REG_TIME_STEP, 0);
		write_reg(REG_ENERGY_UPDATE, 1);
		run_random(250);

		// A zero radius acts as the smallest one.
		idle_enable = 1'b1;
		write_reg(REG_GRAV_RADIUS, 0);
		write_reg(REG_PEAK_ACCEL, 64'h0004_0000);
		write_reg(REG_TIME_STEP, 64'h0000_4000);
		run_random(250);

		// Random settings, with random idling in all passes but the second.
		for (int p = 0; p < 3; p++) begin
			write_reg(REG_GRAV_RADIUS, $urandom >> $urandom_range(1, 31));
			write_reg(REG_PEAK_ACCEL, $urandom >> $urandom_range(1, 31));
			write_reg(REG_TIME_STEP, $urandom >> $urandom_range(1, 31));
			write_reg(REG_ENERGY_UPDATE, $urandom_range(0, 1));
			idle_enable = (p != 1);
			run_random(240);
		end

		repeat (300) @(posedge clk);
		if (mismatches == 0 && expected_updates.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// ===== files.f =====
sv/pngs_pkg.sv
sv/pseudo_newtonian_gravity_source.sv
dv/pseudo_newtonian_gravity_source_tb.sv
